// ===== design/ais_pkg.sv =====
// ----------------------------------------------------------------------------
// ais_pkg
// Shared types for the ascending integer sorter: the cell slot and the
// controller state encoding.
// ----------------------------------------------------------------------------
package ais_pkg;

	localparam int unsigned VALUE_W = 32;

	// One slot of the cell chain: a value and its occupancy flag.
	typedef struct packed {
		logic                      vld;
		logic signed [VALUE_W-1:0] val;
	} slot_t;

	// Control handed to every cell.
	typedef struct packed {
		logic shift;   // drain: take the right neighbor's held slot
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_SETTLE,
		ST_DRAIN
	} ais_state_t;

endpackage

// ===== design/ascending_integer_sorter.sv =====
// ----------------------------------------------------------------------------
// ascending_integer_sorter
// Collects a set of signed 32-bit values in a systolic insertion chain and
// streams it back in ascending order once the last item of the set arrives.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid, in_ready  | value[31:0] signed, last_item
//  output  | out_valid, out_ready| sorted_value[31:0] signed, is_last, overflow
//
// Fill: one transfer per cycle; each value enters cell 0 and ripples right one
//   cell per cycle, the larger of each compare moving on.
// Settle: after the last item, wait until no value is still moving in the
//   chain.
// Drain: one result per cycle while out_ready is high; the chain shifts left,
//   cell 0 is the output register.
// Reset empties every cell; an output stall simply holds the chain.
// Items beyond MAX_ITEMS are dropped and mark the whole set with overflow.
//
module ascending_integer_sorter
	import ais_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sorted_value,
	output logic               is_last,
	output logic               overflow
);

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

	ais_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;

	slot_t     carry [MAX_ITEMS+1];   // carry[i] enters cell i
	slot_t     held  [MAX_ITEMS+1];   // held[MAX_ITEMS] is the empty end
	cell_ctl_t ctl;
	logic      [MAX_ITEMS-1:0] moving;
	logic      in_xfer, out_xfer, room;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign room     = count_q < CNT_W'(MAX_ITEMS);

	// Accepted and kept items enter cell 0
	assign carry[0].vld = in_xfer && room;
	assign carry[0].val = value;
	assign held[MAX_ITEMS].vld = 1'b0;
	assign held[MAX_ITEMS].val = '0;

	assign ctl.shift = out_xfer;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		ais_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.carry_in   (carry[i]),
			.right_held (held[i+1]),
			.carry_out  (carry[i+1]),
			.held       (held[i])
		);
		assign moving[i] = carry[i+1].vld;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				in_ready = 1'b1;
				if (in_valid && last_item) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				if (moving == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				out_valid = held[0].vld;
				if (out_xfer && is_last) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	// Set occupancy and overflow mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (out_xfer && is_last) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (in_xfer) begin
			if (room) begin
				count_q <= count_q + 1'b1;
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	assign sorted_value = held[0].val;
	assign is_last      = !held[1].vld;
	assign overflow     = dropped_q;

	// Results only while draining
	a_out_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_DRAIN)
		else $error("result offered outside drain");

	// Capacity: nothing ever falls off the end of the chain
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!carry[MAX_ITEMS].vld)
		else $error("value spilled past last cell");

	// Chain is empty after the final result of a set
	a_empty_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && is_last) |=> (!held[0].vld && count_q == '0))
		else $error("chain not empty after run");

	// Count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count over capacity");

	// Drain starts only with the chain settled
	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (moving == '0))
		else $error("drain while values still moving");

endmodule

// ===== design/ais_cell.sv =====
// ----------------------------------------------------------------------------
// ais_cell
// One insertion cell. Keeps the smaller of its held value and the arriving
// value, and passes the larger one to the right on the next cycle. In drain
// it loads its right neighbor's held slot.
// ----------------------------------------------------------------------------
module ais_cell
	import ais_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  slot_t     carry_in,
	input  slot_t     right_held,
	output slot_t     carry_out,
	output slot_t     held
);

	logic                      held_vld_q;
	logic                      carry_vld_q;
	logic signed [VALUE_W-1:0] held_val_q;
	logic signed [VALUE_W-1:0] carry_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q  <= 1'b0;
			carry_vld_q <= 1'b0;
		end else begin
			carry_vld_q <= 1'b0;
			if (ctl.shift) begin
				held_vld_q <= right_held.vld;
			end else if (carry_in.vld) begin
				if (!held_vld_q) begin
					held_vld_q <= 1'b1;
				end else begin
					carry_vld_q <= 1'b1;
				end
			end
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			held_val_q <= right_held.val;
		end else if (carry_in.vld) begin
			if (!held_vld_q) begin
				held_val_q <= carry_in.val;
			end else if (carry_in.val < held_val_q) begin
				held_val_q  <= carry_in.val;
				carry_val_q <= held_val_q;
			end else begin
				carry_val_q <= carry_in.val;
			end
		end
	end

	assign held      = '{vld: held_vld_q, val: held_val_q};
	assign carry_out = '{vld: carry_vld_q, val: carry_val_q};

endmodule
